@@ hw/rtl/fprl_pkg.sv @@
// ----------------------------------------------------------------------------
// fprl_pkg
// Shared constants and types for the flash page record log.
// ----------------------------------------------------------------------------
package fprl_pkg;

  localparam int unsigned PageSlots = 256;
  localparam int unsigned SlotW     = (PageSlots > 1) ? $clog2(PageSlots) : 1;
  localparam int unsigned WordW     = 64;

  localparam logic [WordW-1:0] ErasedWord  = {WordW{1'b1}};
  localparam logic [SlotW-1:0] LastSlot    = SlotW'(PageSlots - 1);

  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  typedef struct packed {
    logic             we;
    logic             clear;
    logic [SlotW-1:0] addr;
    logic [WordW-1:0] data;
  } mem_wr_t;

endpackage

@@ hw/rtl/fprl_page_mem.sv @@
// ----------------------------------------------------------------------------
// fprl_page_mem
// Page store: one write port, one registered read port, per-slot valid
// bits so that an erase clears the whole page at once.
// ----------------------------------------------------------------------------
module fprl_page_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fprl_pkg::mem_wr_t         wr,
  input  logic [fprl_pkg::SlotW-1:0] raddr,
  output logic [fprl_pkg::WordW-1:0] rdata
);

  logic [fprl_pkg::WordW-1:0] mem_r [fprl_pkg::PageSlots];
  logic [fprl_pkg::PageSlots-1:0] valid_r, valid_nxt;
  logic [fprl_pkg::WordW-1:0] rd_q_r;
  logic                       vld_q_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_q_r <= mem_r[raddr];
  end

  always_comb begin
    valid_nxt = wr.clear ? '0 : valid_r;
    if (wr.we) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      vld_q_r <= valid_r[raddr];
    end
  end

  assign rdata = vld_q_r ? rd_q_r : fprl_pkg::ErasedWord;

endmodule

@@ hw/rtl/flash_page_record_log_core.sv @@
// ----------------------------------------------------------------------------
// flash_page_record_log_core
// Append-only log of 64-bit records in one erasable page, with compaction
// of a full page and a default record on a read of an empty page.
//
//   channel  handshake          word
//   in       in_valid/in_stall   in_kind, in_record_value
//   out      out_valid/out_stall out_result_value, out_slot_used,
//                                out_page_rotated
//   cfg      cfg_valid/cfg_ready cfg_data (default_record)
//
// A request scans the page from slot 0 up to the first blank slot, one
// read per cycle from the page store's read port. A full page needs no
// separate erase pass: the erase clears all slot valid bits at once.
// Reset is synchronous and leaves the page erased and default_record at 1.
// in_stall is high while a request is in work, also while its result
// waits for the result register that out_stall holds.
// ----------------------------------------------------------------------------
module flash_page_record_log_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_record_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_value,
  output logic [7:0]  out_slot_used,
  output logic        out_page_rotated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StAct
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        kind_r, kind_nxt;
  logic [fprl_pkg::WordW-1:0]  val_r, val_nxt;
  logic [fprl_pkg::WordW-1:0]  prev_r, prev_nxt;
  logic [fprl_pkg::SlotW-1:0]  idx_r, idx_nxt;
  logic [fprl_pkg::SlotW-1:0]  slot_r, slot_nxt;
  logic                        rot_r, rot_nxt;
  logic [fprl_pkg::WordW-1:0]  default_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [63:0]                 out_value_r, out_value_nxt;
  logic [7:0]                  out_slot_r, out_slot_nxt;
  logic                        out_rot_r, out_rot_nxt;

  fprl_pkg::mem_wr_t           wr;
  logic [fprl_pkg::SlotW-1:0]  raddr;
  logic [fprl_pkg::WordW-1:0]  word;

  fprl_page_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .raddr (raddr),
    .rdata (word)
  );

  assign raddr = (state_r == StIdle) ? '0 : idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    rot_nxt       = rot_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_value_nxt = out_value_r;
    out_slot_nxt  = out_slot_r;
    out_rot_nxt   = out_rot_r;
    wr            = '0;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          val_nxt   = in_record_value;
          idx_nxt   = '0;
          rot_nxt   = 1'b0;
          state_nxt = StScan;
        end
      end
      StScan: begin
        if (word == fprl_pkg::ErasedWord) begin
          slot_nxt  = idx_r;
          state_nxt = StAct;
        end else begin
          prev_nxt = word;
          if (idx_r == fprl_pkg::LastSlot) begin
            // compact: erase page, keep last record in slot 0
            wr.we     = 1'b1;
            wr.clear  = 1'b1;
            wr.addr   = '0;
            wr.data   = word;
            slot_nxt  = fprl_pkg::SlotW'(1);
            rot_nxt   = 1'b1;
            state_nxt = StAct;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      StAct: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rot_nxt   = rot_r;
          if (kind_r == fprl_pkg::KindWrite) begin
            wr.we         = 1'b1;
            wr.addr       = slot_r;
            wr.data       = val_r;
            out_value_nxt = val_r;
            out_slot_nxt  = 8'(slot_r);
          end else if (slot_r != '0) begin
            out_value_nxt = prev_r;
            out_slot_nxt  = 8'(slot_r - 1'b1);
          end else begin
            wr.we         = 1'b1;
            wr.addr       = '0;
            wr.data       = default_r;
            out_value_nxt = default_r;
            out_slot_nxt  = '0;
          end
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    val_r       <= val_nxt;
    prev_r      <= prev_nxt;
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    rot_r       <= rot_nxt;
    out_value_r <= out_value_nxt;
    out_slot_r  <= out_slot_nxt;
    out_rot_r   <= out_rot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= 64'd1;
    end else if (cfg_valid && cfg_ready) begin
      default_r <= cfg_data;
    end
  end

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != StIdle);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_slot_used    = out_slot_r;
  assign out_page_rotated = out_rot_r;

endmodule

@@ tb/page_log_checker.sv @@
// ----------------------------------------------------------------------------
// page_log_checker
// Watches the request, result and default_record channels of the flash page
// record log. It keeps its own image of the page, works out the result word
// of every accepted request and compares each accepted result word with the
// oldest one still awaited.
// ----------------------------------------------------------------------------
module page_log_checker
  import fprl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_record_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_result_value,
  input  logic [7:0]  out_slot_used,
  input  logic        out_page_rotated,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          replies_waiting,
  output int          replies_checked,
  output int          compactions,
  output int          default_fills
);

  typedef struct packed {
    logic [WordW-1:0] value;
    logic [7:0]       slot;
    logic             rotated;
  } log_reply_t;

  logic [WordW-1:0] page_words [PageSlots];
  logic [WordW-1:0] default_word;
  log_reply_t       queued_replies [$];

  function automatic log_reply_t serve_log_request(input logic kind,
                                                   input logic [WordW-1:0] record);
    int unsigned      idx;
    int unsigned      blank;
    bit               found;
    logic [WordW-1:0] kept;
    log_reply_t       reply;
    found = 1'b0;
    blank = 0;
    reply.rotated = 1'b0;
    for (idx = 0; idx < PageSlots; idx++) begin
      if (!found && page_words[idx] == ErasedWord) begin
        found = 1'b1;
        blank = idx;
      end
    end
    if (!found) begin
      kept = page_words[PageSlots-1];
      for (idx = 0; idx < PageSlots; idx++) page_words[idx] = ErasedWord;
      page_words[0] = kept;
      blank = 1;
      reply.rotated = 1'b1;
      compactions++;
    end
    if (kind == KindWrite) begin
      page_words[blank] = record;
      reply.value = record;
    end else begin
      if (blank != 0) begin
        blank = blank - 1;
      end else begin
        page_words[0] = default_word;
        default_fills++;
      end
      reply.value = page_words[blank];
    end
    reply.slot = 8'(blank);
    return reply;
  endfunction

  always @(posedge clk) begin : watch
    log_reply_t want;
    int unsigned idx;
    if (!rst_n) begin
      for (idx = 0; idx < PageSlots; idx++) page_words[idx] = ErasedWord;
      default_word = 64'd1;
      queued_replies.delete();
      fail_count = 0;
      replies_checked = 0;
      compactions = 0;
      default_fills = 0;
      replies_waiting = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (queued_replies.size() == 0) begin
          $error("unexpected result word: result_value %h slot_used %0d page_rotated %0b",
                 out_result_value, out_slot_used, out_page_rotated);
          fail_count++;
        end else begin
          want = queued_replies.pop_front();
          replies_checked++;
          if (out_result_value !== want.value) begin
            $error("result_value: expected %h, actual %h", want.value, out_result_value);
            fail_count++;
          end
          if (out_slot_used !== want.slot) begin
            $error("slot_used: expected %0d, actual %0d", want.slot, out_slot_used);
            fail_count++;
          end
          if (out_page_rotated !== want.rotated) begin
            $error("page_rotated: expected %0b, actual %0b", want.rotated, out_page_rotated);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) default_word = cfg_data;
      if (in_valid && !in_stall)
        queued_replies.push_back(serve_log_request(in_kind, in_record_value));
      replies_waiting = queued_replies.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives read and append requests and default_record loads into the flash
// page record log, with random idling on both channels, one long result
// hold-off and one stretch without idling, and reports the verdict of the
// checker that runs beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import fprl_pkg::*;

  localparam int WatchdogLimit = 8000;
  localparam int HoldCycles    = 1200;
  localparam int PhaseItems    = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [63:0] in_record_value;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_value;
  logic [7:0]  out_slot_used;
  logic        out_page_rotated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  int   fail_count;
  int   replies_waiting;
  int   replies_checked;
  int   compactions;
  int   default_fills;
  int   words_in;
  int   quiet_cycles;
  int   reads_sent;
  int   appends_sent;
  int   loads_sent;
  logic calm_run;

  flash_page_record_log_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_record_value  (in_record_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_slot_used    (out_slot_used),
    .out_page_rotated (out_page_rotated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  page_log_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_record_value  (in_record_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_slot_used    (out_slot_used),
    .out_page_rotated (out_page_rotated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .replies_waiting  (replies_waiting),
    .replies_checked  (replies_checked),
    .compactions      (compactions),
    .default_fills    (default_fills)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign calm_run = (words_in >= 1000) && (words_in < 1300);

  always @(posedge clk) begin
    if (!rst_n) begin
      words_in <= 0;
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) words_in <= words_in + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : result_side
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_in >= 700) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm_run) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 34);
      end
    end
  end

  function automatic logic [63:0] pick_record();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return ErasedWord;
    if (roll < 9) return 64'd0;
    if (roll < 13) return 64'd1 << $urandom_range(0, 63);
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic kind, input logic [63:0] value);
    while (!calm_run && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_record_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (kind == KindRead) reads_sent++;
    else appends_sent++;
  endtask

  task automatic load_default(input logic [63:0] value);
    in_valid <= 1'b0;
    while (replies_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    loads_sent++;
  endtask

  task automatic run_phase(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 20) send_word(KindRead, pick_record());
      else send_word(KindWrite, pick_record());
    end
  endtask

  initial begin : stimulus
    logic [63:0] load_values [6];
    int          phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KindRead;
    in_record_value = 64'd0;
    cfg_valid = 1'b0;
    cfg_data = 64'd0;
    reads_sent = 0;
    appends_sent = 0;
    loads_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_default(ErasedWord);
    send_word(KindRead, 64'h0123_4567_89ab_cdef);
    send_word(KindWrite, ErasedWord);
    send_word(KindRead, 64'd0);
    load_default(64'd0);
    send_word(KindRead, ErasedWord);
    send_word(KindRead, 64'hfedc_ba98_7654_3210);
    send_word(KindWrite, 64'd1);
    send_word(KindWrite, 64'h8000_0000_0000_0000);
    send_word(KindWrite, 64'h7fff_ffff_ffff_ffff);
    send_word(KindWrite, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(KindWrite, 64'h5555_5555_5555_5555);
    send_word(KindWrite, ErasedWord);
    send_word(KindRead, 64'd0);
    send_word(KindWrite, 64'hffff_ffff_ffff_fffe);
    send_word(KindWrite, 64'd0);
    send_word(KindRead, ErasedWord);

    load_values[0] = 64'd1;
    load_values[1] = {$urandom, $urandom};
    load_values[2] = ErasedWord;
    load_values[3] = {$urandom, $urandom};
    load_values[4] = 64'd0;
    load_values[5] = 64'h8000_0000_0000_0000;
    for (phase = 0; phase < 6; phase++) begin
      load_default(load_values[phase]);
      run_phase(PhaseItems);
    end

    in_valid <= 1'b0;
    while (replies_waiting != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Covered %0d requests (%0d reads, %0d appends) and %0d default_record loads.",
             reads_sent + appends_sent, reads_sent, appends_sent, loads_sent);
    $display("Compared %0d results, with %0d page compactions and %0d empty-page default fills.",
             replies_checked, compactions, default_fills);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
